// ===== hdl/bfca_pkg.sv =====
// Package for the best-fit coalescing allocator.
// Holds the request and result beat types, command and status codes and config defaults.
// Has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfca_pkg;

	localparam int MAX_EXTENTS_DEFAULT = 64;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic CFG_POOL_BASE   = 1'b0;
	localparam logic CFG_POOL_LENGTH = 1'b1;

	localparam logic [31:0] POOL_BASE_RESET   = 32'd0;
	localparam logic [31:0] POOL_LENGTH_RESET = 32'd65536;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FULL  = 2'd2,
		ST_ZERO  = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] length;
		logic [31:0] address;
	} request_t;

	typedef struct packed {
		logic [31:0] granted_address;
		status_t     status;
		logic [31:0] free_bytes;
		logic [6:0]  extent_count;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/best_fit_coalescing_allocator.sv =====
// Best-fit free-extent allocator with coalescing: extent table memories and sequencer.
// Depends on bfca_pkg for the beat types, codes and config defaults.
//
//   channel   signals                          handshake
//   request   start, busy, request             beat taken when start high and busy low
//   result    done, result                     one-cycle strobe, receiver cannot stall
//   config    cfg_wr_en, cfg_index, cfg_data   written on any edge with cfg_wr_en high
//
// A command is accepted, the table is scanned through the single registered read port, the
// shared adder runs three to five steps, the entries above each dropped entry move down to
// close the gap, the new extent is appended and the result is reported; a free that merges
// both sides closes two gaps. Clear reloads the pool extent and then reports.
// After reset the first extent is written in S_INIT, during which busy is high.
// Results cannot be stalled; busy falls in the cycle the done strobe is shown.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_coalescing_allocator #(
	parameter int MAX_EXTENTS = bfca_pkg::MAX_EXTENTS_DEFAULT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire bfca_pkg::request_t request,
	output logic                    done,
	output bfca_pkg::result_t       result,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam logic [CW-1:0] HELD_MAX = CW'(MAX_EXTENTS);
	localparam logic [CW-1:0] ONE = CW'(1);

	localparam logic [2:0] STEP_0 = 3'd0;
	localparam logic [2:0] STEP_1 = 3'd1;
	localparam logic [2:0] STEP_2 = 3'd2;
	localparam logic [2:0] STEP_3 = 3'd3;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_INIT   = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_MATH   = 7'b0001000,
		S_DROP   = 7'b0010000,
		S_APPEND = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t            state_q;
	logic [1:0]        cmd_q;
	logic [31:0]       len_q;
	logic [31:0]       addr_q;
	bfca_pkg::status_t status_q;
	logic [31:0]       gnt_q;
	logic [CW-1:0]     held_q;
	logic [31:0]       free_total_q;
	logic [31:0]       base_q;
	logic [31:0]       plen_q;
	logic              from_reset_q;
	logic [CW-1:0]     scan_q;
	logic [2:0]        step_q;

	logic              a_found_q;
	logic [CW-1:0]     a_idx_q;
	logic [31:0]       a_start_q;
	logic [31:0]       a_len_q;
	logic              b_found_q;
	logic [CW-1:0]     b_idx_q;
	logic [31:0]       b_start_q;
	logic [31:0]       b_len_q;
	logic              mn_q;
	logic              mp_q;
	logic [31:0]       ns_q;
	logic [31:0]       nl_q;
	logic              drop2_q;
	logic [CW-1:0]     drop_lo_q;
	logic              append_q;

	logic              rd_vld_s1;
	logic [CW-1:0]     rd_idx_s1;
	logic [31:0]       rd_start_s1;
	logic [31:0]       rd_len_s1;

	bfca_pkg::result_t result_q;
	logic              done_q;

	logic [31:0] mem_start [MAX_EXTENTS];
	logic [31:0] mem_len   [MAX_EXTENTS];

	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [31:0]   mem_wstart;
	logic [31:0]   mem_wlen;
	logic [CW-1:0] drop_wr_idx;
	logic [31:0]   held_wide;
	logic          scan_end;

	// Shared add/subtract unit; for a subtraction bit 32 is set when no borrow occurs.
	logic [31:0] add_a;
	logic [31:0] add_b;
	logic        add_sub;
	logic [32:0] add_sum;
	logic [31:0] add_sat;

	assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + 33'(add_sub);
	assign add_sat = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		if (cmd_q == bfca_pkg::CMD_ALLOC) begin
			case (step_q)
				STEP_0: begin
					add_a = a_start_q;
					add_b = len_q;
				end
				STEP_1: begin
					add_a   = a_len_q;
					add_b   = len_q;
					add_sub = 1'b1;
				end
				default: begin
					add_a   = free_total_q;
					add_b   = len_q;
					add_sub = 1'b1;
				end
			endcase
		end else begin
			case (step_q)
				STEP_0: begin
					add_a = addr_q;
					add_b = len_q;
				end
				STEP_1: begin
					add_a = a_start_q;
					add_b = a_len_q;
				end
				STEP_2: begin
					add_a = len_q;
					add_b = mn_q ? b_len_q : 32'd0;
				end
				STEP_3: begin
					add_a = nl_q;
					add_b = mp_q ? a_len_q : 32'd0;
				end
				default: begin
					add_a = free_total_q;
					add_b = len_q;
				end
			endcase
		end
	end

	assign mem_re      = ((state_q == S_SCAN) || (state_q == S_DROP)) && (scan_q < held_q);
	assign mem_raddr   = scan_q[IW-1:0];
	assign drop_wr_idx = rd_idx_s1 - ONE;
	assign scan_end    = !mem_re && !rd_vld_s1;
	assign held_wide   = 32'(held_q);

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wstart = rd_start_s1;
		mem_wlen   = rd_len_s1;
		case (state_q)
			S_INIT: begin
				mem_we     = (plen_q != 32'd0);
				mem_wstart = base_q;
				mem_wlen   = plen_q;
			end
			S_DROP: begin
				mem_we    = rd_vld_s1;
				mem_waddr = drop_wr_idx[IW-1:0];
			end
			S_APPEND: begin
				mem_we     = 1'b1;
				mem_waddr  = held_q[IW-1:0];
				mem_wstart = ns_q;
				mem_wlen   = nl_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_start[mem_waddr] <= mem_wstart;
			mem_len[mem_waddr]   <= mem_wlen;
		end
		if (mem_re) begin
			rd_start_s1 <= mem_start[mem_raddr];
			rd_len_s1   <= mem_len[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			from_reset_q <= 1'b1;
			base_q       <= bfca_pkg::POOL_BASE_RESET;
			plen_q       <= bfca_pkg::POOL_LENGTH_RESET;
			held_q       <= '0;
			free_total_q <= '0;
			scan_q       <= '0;
			step_q       <= STEP_0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			a_found_q    <= 1'b0;
			b_found_q    <= 1'b0;
			drop2_q      <= 1'b0;
			append_q     <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= bfca_pkg::ST_OK;
			cmd_q        <= bfca_pkg::CMD_ALLOC;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= mem_re;
			rd_idx_s1 <= scan_q;
			if (mem_re) begin
				scan_q <= scan_q + ONE;
			end

			if (cfg_wr_en) begin
				case (cfg_index)
					bfca_pkg::CFG_POOL_BASE:   base_q <= cfg_data;
					bfca_pkg::CFG_POOL_LENGTH: plen_q <= cfg_data;
					default:                   base_q <= base_q;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= request.command;
						len_q     <= request.length;
						addr_q    <= request.address;
						status_q  <= bfca_pkg::ST_OK;
						gnt_q     <= '0;
						scan_q    <= '0;
						step_q    <= STEP_0;
						a_found_q <= 1'b0;
						b_found_q <= 1'b0;
						case (request.command)
							bfca_pkg::CMD_ALLOC, bfca_pkg::CMD_FREE: begin
								if (request.length == 32'd0) begin
									status_q <= bfca_pkg::ST_ZERO;
									state_q  <= S_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							bfca_pkg::CMD_CLEAR: begin
								from_reset_q <= 1'b0;
								state_q      <= S_INIT;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end

				S_INIT: begin
					held_q       <= (plen_q != 32'd0) ? ONE : '0;
					free_total_q <= plen_q;
					state_q      <= from_reset_q ? S_IDLE : S_DONE;
				end

				S_SCAN: begin
					if (rd_vld_s1) begin
						if (cmd_q == bfca_pkg::CMD_ALLOC) begin
							if ((rd_len_s1 >= len_q) && (!a_found_q || (rd_len_s1 < a_len_q))) begin
								a_found_q <= 1'b1;
								a_idx_q   <= rd_idx_s1;
								a_start_q <= rd_start_s1;
								a_len_q   <= rd_len_s1;
							end
						end else if (rd_start_s1 <= addr_q) begin
							if (!a_found_q || (rd_start_s1 > a_start_q)) begin
								a_found_q <= 1'b1;
								a_idx_q   <= rd_idx_s1;
								a_start_q <= rd_start_s1;
								a_len_q   <= rd_len_s1;
							end
						end else begin
							if (!b_found_q || (rd_start_s1 < b_start_q)) begin
								b_found_q <= 1'b1;
								b_idx_q   <= rd_idx_s1;
								b_start_q <= rd_start_s1;
								b_len_q   <= rd_len_s1;
							end
						end
					end else if (scan_end) begin
						if ((cmd_q == bfca_pkg::CMD_ALLOC) && !a_found_q) begin
							status_q <= bfca_pkg::ST_NOFIT;
							state_q  <= S_DONE;
						end else begin
							step_q  <= STEP_0;
							state_q <= S_MATH;
						end
					end
				end

				S_MATH: begin
					step_q <= step_q + 3'd1;
					if (cmd_q == bfca_pkg::CMD_ALLOC) begin
						case (step_q)
							STEP_0: ns_q <= add_sum[31:0];
							STEP_1: nl_q <= add_sum[31:0];
							default: begin
								free_total_q <= add_sum[32] ? add_sum[31:0] : 32'd0;
								gnt_q        <= a_start_q;
								append_q     <= (nl_q != 32'd0);
								drop2_q      <= 1'b0;
								scan_q       <= a_idx_q + ONE;
								state_q      <= S_DROP;
							end
						endcase
					end else begin
						case (step_q)
							STEP_0: mn_q <= b_found_q && (add_sum == {1'b0, b_start_q});
							STEP_1: mp_q <= a_found_q && (add_sum == {1'b0, addr_q});
							STEP_2: begin
								if (!mn_q && !mp_q && (held_q == HELD_MAX)) begin
									status_q <= bfca_pkg::ST_FULL;
									state_q  <= S_DONE;
								end else begin
									nl_q <= add_sat;
								end
							end
							STEP_3: begin
								nl_q <= add_sat;
								ns_q <= mp_q ? a_start_q : addr_q;
							end
							default: begin
								free_total_q <= add_sat;
								append_q     <= 1'b1;
								drop2_q      <= mn_q && mp_q;
								// With two neighbours the higher entry goes first, so the
								// lower index still holds for the second pass.
								if (mn_q && mp_q) begin
									scan_q    <= ((a_idx_q > b_idx_q) ? a_idx_q : b_idx_q) + ONE;
									drop_lo_q <= (a_idx_q > b_idx_q) ? b_idx_q : a_idx_q;
									state_q   <= S_DROP;
								end else if (mn_q) begin
									scan_q  <= b_idx_q + ONE;
									state_q <= S_DROP;
								end else if (mp_q) begin
									scan_q  <= a_idx_q + ONE;
									state_q <= S_DROP;
								end else begin
									state_q <= S_APPEND;
								end
							end
						endcase
					end
				end

				S_DROP: begin
					// Entries above the dropped one move down one place, one per cycle.
					if (scan_end) begin
						held_q <= held_q - ONE;
						if (drop2_q) begin
							drop2_q <= 1'b0;
							scan_q  <= drop_lo_q + ONE;
						end else begin
							state_q <= append_q ? S_APPEND : S_DONE;
						end
					end
				end

				S_APPEND: begin
					held_q  <= held_q + ONE;
					state_q <= S_DONE;
				end

				S_DONE: begin
					result_q.granted_address <= gnt_q;
					result_q.status          <= status_q;
					result_q.free_bytes      <= free_total_q;
					result_q.extent_count    <= held_wide[6:0];
					done_q                   <= 1'b1;
					state_q                  <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== sim/tb_best_fit_coalescing_allocator.sv =====
// Self-checking testbench for the best-fit coalescing allocator: command beats are queued and
// driven, and every result beat is checked against a behavioural copy of the extent table.
// Depends on bfca_pkg and best_fit_coalescing_allocator.
`timescale 1ns / 1ps

module tb_best_fit_coalescing_allocator;

	localparam int MAX_EXTENTS = bfca_pkg::MAX_EXTENTS_DEFAULT;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// A free that merges both sides scans once and closes two gaps.
	localparam int SETTLE_CYCLES = 3 * MAX_EXTENTS + 16;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] len;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	bfca_pkg::request_t req_beat = '0;
	logic done;
	bfca_pkg::result_t res_beat;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = bfca_pkg::CFG_POOL_BASE;
	logic [31:0] cfg_data = '0;

	best_fit_coalescing_allocator #(
		.MAX_EXTENTS(MAX_EXTENTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(req_beat),
		.done(done),
		.result(res_beat),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the extent table, kept in insertion order.
	logic [31:0] ext_start [MAX_EXTENTS];
	logic [31:0] ext_len [MAX_EXTENTS];
	int unsigned ext_held;
	logic [31:0] free_sum;
	logic [31:0] pool_base_reg;
	logic [31:0] pool_len_reg;

	bfca_pkg::request_t pending_q [$];
	bfca_pkg::result_t expect_q [$];
	grant_t grant_q [$];
	bfca_pkg::result_t want;
	int gap_pct = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void remove_extent(int unsigned idx);
		for (int unsigned i = idx; i + 1 < ext_held; i++) begin
			ext_start[i] = ext_start[i + 1];
			ext_len[i] = ext_len[i + 1];
		end
		ext_held--;
		ext_start[ext_held] = '0;
		ext_len[ext_held] = '0;
	endfunction

	function automatic void add_extent(logic [31:0] s, logic [31:0] l);
		if (ext_held < MAX_EXTENTS) begin
			ext_start[ext_held] = s;
			ext_len[ext_held] = l;
			ext_held++;
		end
	endfunction

	function automatic void reload_pool();
		for (int i = 0; i < MAX_EXTENTS; i++) begin
			ext_start[i] = '0;
			ext_len[i] = '0;
		end
		ext_held = 0;
		free_sum = pool_len_reg;
		if (pool_len_reg != 0) add_extent(pool_base_reg, pool_len_reg);
		grant_q.delete();
	endfunction

	function automatic bfca_pkg::result_t predict_command(bfca_pkg::request_t req);
		bfca_pkg::result_t res;
		int unsigned best, prev_i, next_i;
		bit found, has_prev, has_next, join_prev, join_next;
		logic [31:0] old_start, old_len, new_start;
		logic [33:0] merged, total;
		res = '0;
		res.status = bfca_pkg::ST_OK;
		case (req.command)
			bfca_pkg::CMD_ALLOC: begin
				if (req.length == 0) begin
					res.status = bfca_pkg::ST_ZERO;
				end else begin
					found = 0;
					best = 0;
					for (int unsigned i = 0; i < ext_held; i++) begin
						if (ext_len[i] >= req.length && (!found || ext_len[i] < ext_len[best])) begin
							best = i;
							found = 1;
						end
					end
					if (!found) begin
						res.status = bfca_pkg::ST_NOFIT;
					end else begin
						old_start = ext_start[best];
						old_len = ext_len[best];
						remove_extent(best);
						if (old_len != req.length)
							add_extent(old_start + req.length, old_len - req.length);
						free_sum = (free_sum >= req.length) ? free_sum - req.length : '0;
						res.granted_address = old_start;
						grant_q = {grant_q, grant_t'({old_start, req.length})};
					end
				end
			end
			bfca_pkg::CMD_FREE: begin
				if (req.length == 0) begin
					res.status = bfca_pkg::ST_ZERO;
				end else begin
					has_prev = 0;
					has_next = 0;
					prev_i = 0;
					next_i = 0;
					for (int unsigned i = 0; i < ext_held; i++) begin
						if (ext_start[i] <= req.address) begin
							if (!has_prev || ext_start[i] > ext_start[prev_i]) begin
								prev_i = i;
								has_prev = 1;
							end
						end else if (!has_next || ext_start[i] < ext_start[next_i]) begin
							next_i = i;
							has_next = 1;
						end
					end
					// Adjacency is judged on the full sum, so nothing matches across the wrap.
					join_next = has_next && (({1'b0, req.address} + {1'b0, req.length})
						== {1'b0, ext_start[next_i]});
					join_prev = has_prev && (({1'b0, ext_start[prev_i]} + {1'b0, ext_len[prev_i]})
						== {1'b0, req.address});
					merged = {2'b00, req.length};
					new_start = req.address;
					if (join_next) merged = merged + ext_len[next_i];
					if (join_prev) begin
						merged = merged + ext_len[prev_i];
						new_start = ext_start[prev_i];
					end
					if (!join_next && !join_prev && ext_held >= MAX_EXTENTS) begin
						res.status = bfca_pkg::ST_FULL;
					end else begin
						// Drop the later entry first so the earlier index stays valid.
						if (join_next && join_prev) begin
							remove_extent((next_i > prev_i) ? next_i : prev_i);
							remove_extent((next_i > prev_i) ? prev_i : next_i);
						end else if (join_next) begin
							remove_extent(next_i);
						end else if (join_prev) begin
							remove_extent(prev_i);
						end
						add_extent(new_start,
							(merged > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : merged[31:0]);
						total = {2'b00, free_sum} + req.length;
						free_sum = (total > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
					end
				end
			end
			bfca_pkg::CMD_CLEAR: begin
				reload_pool();
			end
			default: ;
		endcase
		res.free_bytes = free_sum;
		res.extent_count = 7'(ext_held);
		return res;
	endfunction

	// Driver: the prediction is made at the edge that takes the command beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) expect_q = {expect_q, predict_command(req_beat)};
			if (!start || !busy) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
					req_beat <= pending_q[0];
					pending_q.delete(0);
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expect_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result beat with nothing outstanding: %s %h %0d %h %0d",
						$time, "addr/status/free/count", res_beat.granted_address,
						res_beat.status, res_beat.free_bytes, res_beat.extent_count);
				mismatches++;
			end else begin
				want = expect_q[0];
				expect_q.delete(0);
				if (res_beat.granted_address !== want.granted_address
					|| res_beat.status !== want.status
					|| res_beat.free_bytes !== want.free_bytes
					|| res_beat.extent_count !== want.extent_count) begin
					if (mismatches < 10)
						$display("%0t: expected addr %h status %0d free %h count %0d, %s",
							$time, want.granted_address, want.status, want.free_bytes,
							want.extent_count, "got:");
					if (mismatches < 10)
						$display("%0t: got addr %h status %0d free %h count %0d",
							$time, res_beat.granted_address, res_beat.status,
							res_beat.free_bytes, res_beat.extent_count);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_item(input logic [1:0] cmd, input logic [31:0] len,
		input logic [31:0] addr);
		bfca_pkg::request_t item;
		item.command = cmd;
		item.length = len;
		item.address = addr;
		do @(negedge clk); while (pending_q.size() >= 2);
		pending_q = {pending_q, item};
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending_q.size() != 0 || start || busy || expect_q.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// New register values only take hold at the clear that follows.
	task automatic set_pool(input logic [31:0] base, input logic [31:0] len);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= bfca_pkg::CFG_POOL_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= bfca_pkg::CFG_POOL_LENGTH;
		cfg_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pool_base_reg = base;
		pool_len_reg = len;
		push_item(bfca_pkg::CMD_CLEAR, $urandom, $urandom);
	endtask

	task automatic push_random_item();
		int roll, pick;
		grant_t g;
		logic [31:0] len, cut;
		roll = $urandom_range(99);
		if (roll < 40) begin
			len = ($urandom_range(99) < 15) ? $urandom : $urandom_range(256, 1);
			push_item(bfca_pkg::CMD_ALLOC, len, $urandom);
		end else if (roll < 50 && ext_held != 0) begin
			// Exact fit; equal extents make the earliest-inserted rule matter.
			push_item(bfca_pkg::CMD_ALLOC, ext_len[$urandom_range(ext_held - 1)], $urandom);
		end else if (roll < 80 && grant_q.size() != 0) begin
			pick = $urandom_range(grant_q.size() - 1);
			g = grant_q[pick];
			grant_q.delete(pick);
			if (g.len > 1 && $urandom_range(3) == 0) begin
				// Hand back the front part only; the tail stays allocated.
				cut = $urandom_range(g.len - 1, 1);
				grant_q = {grant_q, grant_t'({g.addr + cut, g.len - cut})};
				g.len = cut;
			end
			push_item(bfca_pkg::CMD_FREE, g.len, g.addr);
		end else if (roll < 87) begin
			len = ($urandom_range(1) != 0) ? $urandom : $urandom_range(4096, 1);
			push_item(bfca_pkg::CMD_FREE, len, $urandom);
		end else if (roll < 91) begin
			push_item(($urandom_range(1) != 0) ? bfca_pkg::CMD_ALLOC : bfca_pkg::CMD_FREE,
				'0, $urandom);
		end else if (roll < 94) begin
			push_item(bfca_pkg::CMD_CLEAR, $urandom, $urandom);
		end else if (roll < 96) begin
			push_item(CMD_UNUSED, $urandom, $urandom);
		end else if (ext_held != 0) begin
			// A return that butts against a free extent on one side.
			pick = $urandom_range(ext_held - 1);
			len = $urandom_range(64, 1);
			if ($urandom_range(1) != 0)
				push_item(bfca_pkg::CMD_FREE, len, ext_start[pick] + ext_len[pick]);
			else
				push_item(bfca_pkg::CMD_FREE, len, ext_start[pick] - len);
		end else begin
			push_item(bfca_pkg::CMD_ALLOC, $urandom_range(256, 1), $urandom);
		end
	endtask

	// Carve the pool into contiguous pieces, return every second one so that the table
	// overflows, then return the rest so that they coalesce with the returned neighbours.
	task automatic fragment_pool(input int pieces);
		grant_t piece [$];
		int order [$];
		int j, tmp;
		for (int i = 0; i < pieces; i++)
			push_item(bfca_pkg::CMD_ALLOC, $urandom_range(24, 1), $urandom);
		wait_idle();
		piece = grant_q;
		grant_q.delete();
		for (int i = 0; i < piece.size(); i += 2) order = {order, i};
		for (int i = order.size() - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 1; i < piece.size(); i += 2) order = {order, i};
		foreach (order[k])
			push_item(bfca_pkg::CMD_FREE, piece[order[k]].len, piece[order[k]].addr);
	endtask

	initial begin
		pool_base_reg = bfca_pkg::POOL_BASE_RESET;
		pool_len_reg = bfca_pkg::POOL_LENGTH_RESET;
		reload_pool();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats on the reset pool of 64 KiB at address zero.
		gap_pct = 0;
		push_item(bfca_pkg::CMD_ALLOC, '0, 32'h0000_0000);
		push_item(bfca_pkg::CMD_FREE, '0, 32'h0000_1234);
		push_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(bfca_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(bfca_pkg::CMD_ALLOC, 32'd100, '0);
		push_item(bfca_pkg::CMD_ALLOC, 32'd100, '0);
		push_item(bfca_pkg::CMD_ALLOC, 32'd50, '0);
		push_item(bfca_pkg::CMD_FREE, 32'd100, 32'd0);
		push_item(bfca_pkg::CMD_FREE, 32'd50, 32'd200);
		push_item(bfca_pkg::CMD_FREE, 32'd100, 32'd100);
		push_item(bfca_pkg::CMD_ALLOC, 32'd65536, '0);
		push_item(bfca_pkg::CMD_ALLOC, 32'd1, '0);
		push_item(bfca_pkg::CMD_FREE, 32'd65536, 32'd0);
		push_item(bfca_pkg::CMD_ALLOC, 32'd10, '0);
		push_item(bfca_pkg::CMD_ALLOC, 32'd20, '0);
		push_item(bfca_pkg::CMD_ALLOC, 32'd10, '0);
		push_item(bfca_pkg::CMD_ALLOC, 32'd20, '0);
		push_item(bfca_pkg::CMD_FREE, 32'd10, 32'd0);
		push_item(bfca_pkg::CMD_FREE, 32'd10, 32'd30);
		push_item(bfca_pkg::CMD_ALLOC, 32'd10, '0);
		push_item(bfca_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(bfca_pkg::CMD_FREE, 32'h0000_0020, 32'hFFFF_FFF0);
		push_item(bfca_pkg::CMD_CLEAR, '0, '0);

		gap_pct = 88;
		repeat (300) push_random_item();

		gap_pct = 30;
		set_pool($urandom & 32'hFFFF_F000, 32'd4096);
		fragment_pool(140);
		gap_pct = 0;
		repeat (150) push_random_item();

		gap_pct = 88;
		set_pool($urandom, 32'd0);
		repeat (60) push_random_item();

		gap_pct = 30;
		set_pool(32'hFFFF_F000, 32'h0000_2000);
		repeat (200) push_random_item();

		// Whole address space: merged lengths and the free total both saturate, and the
		// total later bottoms out at zero.
		gap_pct = 0;
		set_pool(32'd0, 32'hFFFF_FFFF);
		push_item(bfca_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(bfca_pkg::CMD_ALLOC, 32'hFFFF_FFFF, '0);
		push_item(bfca_pkg::CMD_FREE, 32'h0000_0100, 32'h0001_0000);
		push_item(bfca_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'h0002_0000);
		push_item(bfca_pkg::CMD_ALLOC, 32'hFFFF_FFFF, '0);
		push_item(bfca_pkg::CMD_ALLOC, 32'h0000_0100, '0);
		push_item(bfca_pkg::CMD_CLEAR, '0, '0);
		repeat (200) push_random_item();

		gap_pct = 88;
		set_pool($urandom, $urandom);
		repeat (250) push_random_item();

		wait_idle();
		if (mismatches == 0 && expect_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/bfca_pkg.sv
hdl/best_fit_coalescing_allocator.sv
sim/tb_best_fit_coalescing_allocator.sv
